FILE: design/gpd_pkg.sv
// Shared types, constants and the 3x3 peak test for the grid peak detector.
// No dependencies; gpd_if, gpd_ctrl, gpd_eval and the top level use this package.
package gpd_pkg;

  // Sizing of the grid and of the cell values.
  localparam int MAX_WIDTH  = 1024;
  localparam int VALUE_BITS = 16;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int DIM_BITS   = 11;
  localparam int POS_BITS   = 10;
  localparam int ENTRY_BITS = 2 * VALUE_BITS;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0] DIM_MAX_W = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0] DIM_MAX_H = DIM_BITS'(MAX_ROWS);

  // Configuration register indexes.
  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef value_t win_t [9];

  // Position of one cell in the frame, with its edge flags.
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last_row;
    logic                last_col;
  } pos_t;

  // True when window cell (cy,cx) is strictly above every neighbor that
  // lies inside the grid. The flags tell which sides have grid neighbors.
  function automatic logic is_peak(win_t win, int cy, int cx, logic up_ok,
                                   logic dn_ok, logic lf_ok, logic rt_ok);
    logic ok;
    logic row_ok;
    logic col_ok;
    int   y;
    int   x;
    ok = 1'b1;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y = cy + dy;
        x = cx + dx;
        row_ok = (dy < 0) ? up_ok : ((dy > 0) ? dn_ok : 1'b1);
        col_ok = (dx < 0) ? lf_ok : ((dx > 0) ? rt_ok : 1'b1);
        if (!(dy == 0 && dx == 0) && y >= 0 && y <= 2 && x >= 0 && x <= 2) begin
          if (row_ok && col_ok &&
              ($signed(win[cy*3+cx]) <= $signed(win[y*3+x]))) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

FILE: design/gpd_if.sv
// Handshake interfaces for the cell input channel and the peak result channel.
// Depends on gpd_pkg for the field widths.
interface gpd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [gpd_pkg::VALUE_BITS-1:0] cell_value;

  modport source(output valid, output cell_value, input ready);
  modport sink(input valid, input cell_value, output ready);
endinterface

interface gpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gpd_pkg::POS_BITS-1:0]  peak_row;
  logic [gpd_pkg::POS_BITS-1:0]  peak_col;
  logic                          run_last;

  modport source(output valid, output peak_row, output peak_col, output run_last,
                 input ready);
  modport sink(input valid, input peak_row, input peak_col, input run_last,
               output ready);
endinterface

FILE: design/gpd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/gpd_ctrl.sv
// Grid size registers and raster position counters of the peak detector.
// Depends on gpd_pkg.
module gpd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  gpd_pkg::cfg_idx_t              cfg_index,
  input  logic [gpd_pkg::DIM_BITS-1:0]   cfg_wdata,
  input  logic                           in_accept,
  output gpd_pkg::pos_t                  pos
);
  import gpd_pkg::*;

  logic [DIM_BITS-1:0] grid_width_r;
  logic [DIM_BITS-1:0] grid_height_r;
  logic [ROW_BITS-1:0] row_r;
  logic [ROW_BITS-1:0] row_nxt;
  logic [COL_BITS-1:0] col_r;
  logic [COL_BITS-1:0] col_nxt;
  logic [DIM_BITS-1:0] eff_w;
  logic [DIM_BITS-1:0] eff_h;
  logic                last_col;
  logic                last_row;

  // Zero acts as one; oversize values clamp to the largest grid.
  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = DIM_BITS'(1);
    end else if (grid_width_r > DIM_MAX_W) begin
      eff_w = DIM_MAX_W;
    end else begin
      eff_w = grid_width_r;
    end
    if (grid_height_r == '0) begin
      eff_h = DIM_BITS'(1);
    end else if (grid_height_r > DIM_MAX_H) begin
      eff_h = DIM_MAX_H;
    end else begin
      eff_h = grid_height_r;
    end
  end

  assign last_col = (DIM_BITS'(col_r) + DIM_BITS'(1)) == eff_w;
  assign last_row = (DIM_BITS'(row_r) + DIM_BITS'(1)) == eff_h;

  // Raster advance with wrap after the last cell of the frame.
  always_comb begin
    col_nxt = col_r + COL_BITS'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
    end
  end

  // Configuration writes; any write restarts the frame at the origin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
      row_r         <= '0;
      col_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
      row_r <= '0;
      col_r <= '0;
    end else if (in_accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign pos = '{row: row_r, col: col_r, last_row: last_row, last_col: last_col};

endmodule

FILE: design/gpd_eval.sv
// Input register, row store, 3x3 window and peak test with the result register.
// Depends on gpd_pkg and gpd_ram.
module gpd_eval (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [gpd_pkg::VALUE_BITS-1:0] in_value,
  input  gpd_pkg::pos_t                  in_pos,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gpd_pkg::POS_BITS-1:0]   out_row,
  output logic [gpd_pkg::POS_BITS-1:0]   out_col
);
  import gpd_pkg::*;

  logic                  in_accept;
  logic                  s1_v_r;
  value_t                s1_val_r;
  pos_t                  s1_pos_r;
  logic                  s1_fire;
  logic                  hit_r;
  logic [ENTRY_BITS-1:0] byp_r;
  logic [ENTRY_BITS-1:0] ram_rdata;
  logic [ENTRY_BITS-1:0] entry;
  logic [ENTRY_BITS-1:0] ram_wdata;
  value_t                above;
  value_t                above2;
  value_t                col_new [3];
  win_t                  win_r;
  win_t                  win_nxt;
  logic                  r_ge1, r_ge2, c_ge1, c_ge2;
  logic                  pk_a, pk_b, pk_c, pk_d;
  logic                  found;
  logic [ROW_BITS-1:0]   row_m1;
  logic [COL_BITS-1:0]   col_m1;
  logic [ROW_BITS-1:0]   pk_row;
  logic [COL_BITS-1:0]   pk_col;
  logic                  out_v_r;
  logic [POS_BITS-1:0]   out_row_r;
  logic [POS_BITS-1:0]   out_col_r;

  // Stage handshake: the input register moves on when the result slot frees.
  assign s1_fire   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || s1_fire;
  assign in_accept = in_valid && in_ready;

  // One RAM entry per column holds the two previous rows: {row r-1, row r-2}.
  assign ram_wdata = {s1_val_r, above};

  gpd_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_pos_r.col),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(in_pos.col),
    .rdata(ram_rdata)
  );

  // A read in the same cycle as a write to that column takes the new entry.
  assign entry  = hit_r ? byp_r : ram_rdata;
  assign above  = entry[ENTRY_BITS-1:VALUE_BITS];
  assign above2 = entry[VALUE_BITS-1:0];

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_val_r <= in_value;
      s1_pos_r <= in_pos;
      hit_r    <= s1_fire && (s1_pos_r.col == in_pos.col);
      byp_r    <= ram_wdata;
    end
  end

  // Window shifts one column left and takes the new column on the right.
  always_comb begin
    col_new[0] = above2;
    col_new[1] = above;
    col_new[2] = s1_val_r;
    for (int y = 0; y < 3; y++) begin
      win_nxt[y*3+0] = win_r[y*3+1];
      win_nxt[y*3+1] = win_r[y*3+2];
      win_nxt[y*3+2] = col_new[y];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_r <= win_nxt;
    end
  end

  // The four cells whose last neighbor arrives with this beat.
  assign r_ge1 = s1_pos_r.row != '0;
  assign r_ge2 = s1_pos_r.row >= ROW_BITS'(2);
  assign c_ge1 = s1_pos_r.col != '0;
  assign c_ge2 = s1_pos_r.col >= COL_BITS'(2);

  assign pk_a = r_ge1 && c_ge1 &&
                is_peak(win_nxt, 1, 1, r_ge2, 1'b1, c_ge2, 1'b1);
  assign pk_b = r_ge1 && s1_pos_r.last_col &&
                is_peak(win_nxt, 1, 2, r_ge2, 1'b1, c_ge1, 1'b0);
  assign pk_c = s1_pos_r.last_row && c_ge1 &&
                is_peak(win_nxt, 2, 1, r_ge1, 1'b0, c_ge2, 1'b1);
  assign pk_d = s1_pos_r.last_row && s1_pos_r.last_col &&
                is_peak(win_nxt, 2, 2, r_ge1, 1'b0, c_ge1, 1'b0);

  // The candidates are mutual grid neighbors, so at most one is a strict peak.
  assign found  = pk_a || pk_b || pk_c || pk_d;
  assign row_m1 = s1_pos_r.row - ROW_BITS'(1);
  assign col_m1 = s1_pos_r.col - COL_BITS'(1);

  always_comb begin
    pk_row = s1_pos_r.row;
    pk_col = s1_pos_r.col;
    if (pk_a) begin
      pk_row = row_m1;
      pk_col = col_m1;
    end else if (pk_b) begin
      pk_row = row_m1;
    end else if (pk_c) begin
      pk_col = col_m1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= found;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && found) begin
      out_row_r <= POS_BITS'(pk_row);
      out_col_r <= POS_BITS'(pk_col);
    end
  end

  assign out_valid = out_v_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;

endmodule

FILE: design/grid_peak_detector_3x3_top.sv
// Top level of the 3x3 strict local-maximum detector on a raster cell stream.
// Depends on gpd_pkg, gpd_if, gpd_ctrl, gpd_eval and gpd_ram.
//
// Cells arrive in raster order, one per input beat, and the block takes one
// beat every clock cycle unless a peak result waits on the output. A peak enters
// the result register when the beat that delivers the last neighbor of the
// peak cell leaves the input register; a beat yields at most one peak, so
// run_last is always set. The rate is set by the row store: one 1024 x 32 RAM
// with a registered read holds the two previous rows, read and rewritten once
// per beat, with a bypass for a one-column grid. The row store is not cleared
// after reset. Writing either size register restarts the frame at row 0,
// column 0; a size of zero counts as one and sizes above 1024 count as 1024.
module grid_peak_detector_3x3_top (
  input  logic                           clk,
  input  logic                           rst_n,
  gpd_in_if.sink                         in_if,
  gpd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  gpd_pkg::cfg_idx_t              cfg_index,
  input  logic [gpd_pkg::DIM_BITS-1:0]   cfg_wdata
);
  import gpd_pkg::*;

  pos_t pos;
  logic in_ready;
  logic in_accept;

  assign in_accept = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // Size registers and raster position.
  gpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_accept(in_accept),
    .pos      (pos)
  );

  // Row store, window and peak test.
  gpd_eval u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_value (in_if.cell_value),
    .in_pos   (pos),
    .in_ready (in_ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .out_row  (out_if.peak_row),
    .out_col  (out_if.peak_col)
  );

  assign out_if.run_last = 1'b1;

endmodule
